// ===== rtl/two_priority_event_queue_macros.svh =====
// Assertion macros for the event queue block.
`ifndef TWO_PRIORITY_EVENT_QUEUE_MACROS_SVH
`define TWO_PRIORITY_EVENT_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
`define TPEQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TPEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TPEQ_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TPEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/tpeq_pkg.sv =====
// ----------------------------------------------------------------------------
// tpeq_pkg
// Shared types and codes for the two-priority event queue.
// ----------------------------------------------------------------------------
`default_nettype none
package tpeq_pkg;
    typedef enum logic [1:0] {
        MODE_PUSH   = 2'd0,
        MODE_POP    = 2'd1,
        MODE_IGNORE = 2'd2,
        MODE_STATS  = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t       mode;
        logic        sel;
        logic [4:0]  etype;
        logic [31:0] arg;
        logic        bad_type;
        logic        coal;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_EXEC,
        ST_OUT
    } state_t;
endpackage
`default_nettype wire

// ===== rtl/two_priority_event_queue.sv =====
// ----------------------------------------------------------------------------
// two_priority_event_queue
// Fault and normal event ring buffers with coalescing and statistics.
// ----------------------------------------------------------------------------
// Use: commands enter on in_valid/in_ready (mode, queue_sel, event_type,
// event_arg); each produces exactly one result transfer on out_valid/out_ready.
// cfg_we writes coalesce_mask at any idle time.
// The front end classifies commands into a two-entry queue; the back end runs
// one command at a time through a sequencer over the buffer memories.
// Each command passes through the READ, EXEC and OUT states; a coalescing push
// also scans the chosen queue one entry a cycle in the SCAN state.
// Reset empties both queues and clears all counters and the mask; buffer
// contents are not cleared. A stalled receiver holds the result; the front
// queue keeps accepting until it holds two commands.
// ----------------------------------------------------------------------------
`default_nettype none
module two_priority_event_queue
    import tpeq_pkg::*;
#(
    parameter int FAULT_DEPTH  = 8,
    parameter int NORMAL_DEPTH = 16,
    parameter int NUM_TYPES    = 32,
    parameter int ARG_BITS     = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  mode,
    input  wire logic        queue_sel,
    input  wire logic [4:0]  event_type,
    input  wire logic [31:0] event_arg,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             ok,
    output logic [4:0]       out_type,
    output logic [31:0]      out_arg,
    output logic [31:0]      pushed_count,
    output logic [31:0]      popped_count,
    output logic [31:0]      dropped_count,
    output logic [31:0]      coalesced_count,
    output logic [31:0]      ignored_count
);
    cmd_t cmd;
    logic cmd_valid, cmd_ready;

    tpeq_front #(.NUM_TYPES(NUM_TYPES)) u_front (
        .clk, .rst_n, .cfg_we, .cfg_data, .in_valid, .in_ready,
        .mode, .queue_sel, .event_type, .event_arg,
        .cmd_valid, .cmd_ready, .cmd
    );

    tpeq_back #(
        .FAULT_DEPTH(FAULT_DEPTH), .NORMAL_DEPTH(NORMAL_DEPTH), .ARG_BITS(ARG_BITS)
    ) u_back (
        .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd, .out_valid, .out_ready,
        .ok, .out_type, .out_arg, .pushed_count, .popped_count,
        .dropped_count, .coalesced_count, .ignored_count
    );
endmodule
`default_nettype wire

// ===== rtl/tpeq_front.sv =====
// ----------------------------------------------------------------------------
// tpeq_front
// Accepts commands, classifies the type and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module tpeq_front
    import tpeq_pkg::*;
#(
    parameter int NUM_TYPES = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  mode,
    input  wire logic        queue_sel,
    input  wire logic [4:0]  event_type,
    input  wire logic [31:0] event_arg,
    output logic             cmd_valid,
    input  wire logic        cmd_ready,
    output cmd_t             cmd
);
    logic [31:0] mask_reg;
    cmd_t        buf_reg [2];
    logic [1:0]  cnt_reg;
    logic        wp_reg, rp_reg;
    cmd_t        c_in;
    logic        push, pop;

    always_comb
    begin
        c_in.mode     = mode_t'(mode);
        c_in.sel      = queue_sel;
        c_in.etype    = event_type;
        c_in.arg      = event_arg;
        c_in.bad_type = (event_type == 5'd0) || ({27'd0, event_type} >= NUM_TYPES);
        c_in.coal     = mask_reg[event_type];
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign push      = in_valid && in_ready;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = buf_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
            cnt_reg  <= '0;
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                mask_reg <= cfg_data;
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wp_reg] <= c_in;
    end
endmodule
`default_nettype wire

// ===== rtl/tpeq_back.sv =====
// ----------------------------------------------------------------------------
// tpeq_back
// Executes queued commands against the two ring buffers and counters.
// ----------------------------------------------------------------------------
`default_nettype none
`include "two_priority_event_queue_macros.svh"
module tpeq_back
    import tpeq_pkg::*;
#(
    parameter int FAULT_DEPTH  = 8,
    parameter int NORMAL_DEPTH = 16,
    parameter int ARG_BITS     = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cmd_valid,
    output logic             cmd_ready,
    input  wire cmd_t        cmd,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             ok,
    output logic [4:0]       out_type,
    output logic [31:0]      out_arg,
    output logic [31:0]      pushed_count,
    output logic [31:0]      popped_count,
    output logic [31:0]      dropped_count,
    output logic [31:0]      coalesced_count,
    output logic [31:0]      ignored_count
);
    localparam int FW = (FAULT_DEPTH > 1) ? $clog2(FAULT_DEPTH) : 1;
    localparam int NW = (NORMAL_DEPTH > 1) ? $clog2(NORMAL_DEPTH) : 1;
    localparam int EW = 5 + ARG_BITS;

    logic [EW-1:0] fmem [FAULT_DEPTH];
    logic [EW-1:0] nmem [NORMAL_DEPTH];

    state_t state_reg, state_next;
    cmd_t   c_reg;
    logic [FW-1:0] fh_reg, ft_reg, fh_next, ft_next, fi_reg, fi_next;
    logic [NW-1:0] nh_reg, nt_reg, nh_next, nt_next, ni_reg, ni_next;
    logic [31:0] fc_reg [4], nc_reg [5];
    logic [EW-1:0] rd_reg;
    logic dup_reg;
    logic f_empty, n_empty, scan_end, scan_hit;
    logic [FW-1:0] fh_inc, ft_inc;
    logic [NW-1:0] nh_inc, nt_inc;
    logic ok_reg;
    logic [4:0] ot_reg;
    logic [31:0] oa_reg, r0, r1, r2, r3, r4;
    logic take;

    assign f_empty = (fh_reg == ft_reg);
    assign n_empty = (nh_reg == nt_reg);
    assign fh_inc  = (fh_reg == FW'(FAULT_DEPTH - 1)) ? '0 : fh_reg + 1'b1;
    assign ft_inc  = (ft_reg == FW'(FAULT_DEPTH - 1)) ? '0 : ft_reg + 1'b1;
    assign nh_inc  = (nh_reg == NW'(NORMAL_DEPTH - 1)) ? '0 : nh_reg + 1'b1;
    assign nt_inc  = (nt_reg == NW'(NORMAL_DEPTH - 1)) ? '0 : nt_reg + 1'b1;
    assign scan_end = c_reg.sel ? (fi_reg == fh_reg) : (ni_reg == nh_reg);
    assign scan_hit = (rd_reg[EW-1 -: 5] == c_reg.etype);
    assign take = cmd_valid && cmd_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (cmd_valid)
                state_next = ST_READ;
            ST_READ: if (c_reg.mode == MODE_PUSH && c_reg.coal && !c_reg.bad_type)
                state_next = ST_SCAN;
            else
                state_next = ST_EXEC;
            ST_SCAN: if (scan_end || dup_reg)
                state_next = ST_EXEC;
            ST_EXEC: state_next = ST_OUT;
            ST_OUT:  if (out_ready)
                state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath next values
    always_comb
    begin
        cmd_ready = (state_reg == ST_IDLE);
        out_valid = (state_reg == ST_OUT);
        fh_next = fh_reg; ft_next = ft_reg; nh_next = nh_reg; nt_next = nt_reg;
        fi_next = fi_reg; ni_next = ni_reg;
        case (state_reg)
            ST_READ:
            begin
                fi_next  = ft_reg;
                ni_next  = nt_reg;
            end
            ST_SCAN:
            begin
                // rd_reg holds the entry read at the previous index
                if (!scan_end && !dup_reg)
                begin
                    if (c_reg.sel)
                        fi_next = (fi_reg == FW'(FAULT_DEPTH - 1)) ? '0 : fi_reg + 1'b1;
                    else
                        ni_next = (ni_reg == NW'(NORMAL_DEPTH - 1)) ? '0 : ni_reg + 1'b1;
                end
            end
            ST_EXEC:
            begin
                if (c_reg.mode == MODE_PUSH && !c_reg.bad_type && !dup_reg)
                begin
                    if (c_reg.sel)
                    begin
                        fh_next = fh_inc;
                        if (fh_inc == ft_reg)
                            ft_next = ft_inc;
                    end
                    else if (nh_inc != nt_reg)
                        nh_next = nh_inc;
                end
                else if (c_reg.mode == MODE_POP)
                begin
                    if (!f_empty)
                        ft_next = ft_inc;
                    else if (!n_empty)
                        nt_next = nt_inc;
                end
            end
            default: ;
        endcase
    end

    // scan reads are registered: the hit check is of the index read last cycle
    logic scan_vld_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fh_reg <= '0; ft_reg <= '0; nh_reg <= '0; nt_reg <= '0;
            fi_reg <= '0; ni_reg <= '0; dup_reg <= 1'b0; scan_vld_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
                fc_reg[i] <= '0;
            for (int i = 0; i < 5; i++)
                nc_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fh_reg <= fh_next; ft_reg <= ft_next; nh_reg <= nh_next; nt_reg <= nt_next;
            fi_reg <= fi_next; ni_reg <= ni_next;
            scan_vld_reg <= (state_reg == ST_SCAN) && !scan_end && !dup_reg;
            if (state_reg == ST_READ)
                dup_reg <= 1'b0;
            else if (state_reg == ST_SCAN && scan_vld_reg && scan_hit)
                dup_reg <= 1'b1;
            if (state_reg == ST_EXEC)
            begin
                case (c_reg.mode)
                    MODE_PUSH: if (!c_reg.bad_type)
                    begin
                        if (dup_reg)
                        begin
                            if (c_reg.sel) fc_reg[3] <= fc_reg[3] + 1'b1;
                            else           nc_reg[3] <= nc_reg[3] + 1'b1;
                        end
                        else if (c_reg.sel)
                        begin
                            fc_reg[0] <= fc_reg[0] + 1'b1;
                            if (fh_inc == ft_reg) fc_reg[2] <= fc_reg[2] + 1'b1;
                        end
                        else if (nh_inc == nt_reg)
                            nc_reg[2] <= nc_reg[2] + 1'b1;
                        else
                            nc_reg[0] <= nc_reg[0] + 1'b1;
                    end
                    MODE_POP:
                        if (!f_empty) fc_reg[1] <= fc_reg[1] + 1'b1;
                        else if (!n_empty) nc_reg[1] <= nc_reg[1] + 1'b1;
                    MODE_IGNORE: nc_reg[4] <= nc_reg[4] + 1'b1;
                    default: ;
                endcase
            end
        end
    end

    // the scan ends on the index check, but the last read entry still needs its hit check;
    // it is made in the final SCAN state through scan_vld_reg, and last_hit also guards the write
    logic last_hit;
    assign last_hit = scan_vld_reg && scan_hit;

    always_ff @(posedge clk)
    begin
        if (take)
            c_reg <= cmd;
        if (state_reg == ST_SCAN)
            rd_reg <= c_reg.sel ? fmem[fi_reg] : nmem[ni_reg];
        else if (state_reg == ST_EXEC)
            rd_reg <= f_empty ? nmem[nt_reg] : fmem[ft_reg];
        if (state_reg == ST_EXEC && c_reg.mode == MODE_PUSH && !c_reg.bad_type
            && !(dup_reg || last_hit))
        begin
            if (c_reg.sel)
                fmem[fh_reg] <= {c_reg.etype, c_reg.arg[ARG_BITS-1:0]};
            else if (nh_inc != nt_reg)
                nmem[nh_reg] <= {c_reg.etype, c_reg.arg[ARG_BITS-1:0]};
        end
    end

    always_comb
    begin
        r0 = '0; r1 = '0; r2 = '0; r3 = '0; r4 = '0;
        if (c_reg.mode == MODE_STATS)
        begin
            if (c_reg.sel)
            begin
                r0 = fc_reg[0]; r1 = fc_reg[1]; r2 = fc_reg[2]; r3 = fc_reg[3];
            end
            else
            begin
                r0 = nc_reg[0]; r1 = nc_reg[1]; r2 = nc_reg[2]; r3 = nc_reg[3];
                r4 = nc_reg[4];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EXEC)
        begin
            ot_reg <= '0;
            oa_reg <= '0;
            case (c_reg.mode)
                MODE_PUSH:   ok_reg <= !c_reg.bad_type &&
                                       (dup_reg || c_reg.sel || nh_inc != nt_reg);
                MODE_POP:
                begin
                    ok_reg <= !(f_empty && n_empty);
                    if (!f_empty)
                    begin
                        ot_reg <= fmem[ft_reg][EW-1 -: 5];
                        oa_reg <= 32'(fmem[ft_reg][ARG_BITS-1:0]);
                    end
                    else if (!n_empty)
                    begin
                        ot_reg <= nmem[nt_reg][EW-1 -: 5];
                        oa_reg <= 32'(nmem[nt_reg][ARG_BITS-1:0]);
                    end
                end
                default:     ok_reg <= 1'b1;
            endcase
        end
    end

    assign ok = ok_reg;
    assign out_type = ot_reg;
    assign out_arg = oa_reg;
    assign pushed_count = r0;
    assign popped_count = r1;
    assign dropped_count = r2;
    assign coalesced_count = r3;
    assign ignored_count = r4;

    `TPEQ_ASSERT_IMPL(a_no_take_busy, clk, rst_n, state_reg != ST_IDLE, !cmd_ready)
    `TPEQ_ASSERT_NEXT(a_exec_out, clk, rst_n, state_reg == ST_EXEC, state_reg == ST_OUT)
    `TPEQ_ASSERT_NEXT(a_take_read, clk, rst_n, take, state_reg == ST_READ)
endmodule
`default_nettype wire

// ===== sim/two_priority_event_queue_test.sv =====
// ----------------------------------------------------------------------------
// two_priority_event_queue_test
// Drives random and directed commands into the event queue, predicts every
// result with a behavioral copy of both ring buffers and their counters, and
// compares each result transfer field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none
module two_priority_event_queue_test;
    timeunit 1ns;
    timeprecision 1ps;
    import tpeq_pkg::*;

    localparam int FDEPTH = 8;
    localparam int NDEPTH = 16;
    localparam int NTYPES = 32;

    // Counter slots
    localparam int C_PUSH = 0;
    localparam int C_POP  = 1;
    localparam int C_DROP = 2;
    localparam int C_COAL = 3;
    localparam int C_IGN  = 4;

    typedef struct packed {
        mode_t       mode;
        logic        sel;
        logic [4:0]  etype;
        logic [31:0] arg;
    } command_t;

    typedef struct packed {
        logic        ok;
        logic [4:0]  etype;
        logic [31:0] arg;
        logic [31:0] c_push;
        logic [31:0] c_pop;
        logic [31:0] c_drop;
        logic [31:0] c_coal;
        logic [31:0] c_ign;
    } outcome_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  mode;
    logic        queue_sel;
    logic [4:0]  event_type;
    logic [31:0] event_arg;
    logic        out_valid;
    logic        out_ready;
    logic        ok;
    logic [4:0]  out_type;
    logic [31:0] out_arg;
    logic [31:0] pushed_count;
    logic [31:0] popped_count;
    logic [31:0] dropped_count;
    logic [31:0] coalesced_count;
    logic [31:0] ignored_count;

    two_priority_event_queue u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .mode            (mode),
        .queue_sel       (queue_sel),
        .event_type      (event_type),
        .event_arg       (event_arg),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .ok              (ok),
        .out_type        (out_type),
        .out_arg         (out_arg),
        .pushed_count    (pushed_count),
        .popped_count    (popped_count),
        .dropped_count   (dropped_count),
        .coalesced_count (coalesced_count),
        .ignored_count   (ignored_count)
    );

    // Shadow state of the block
    logic [31:0] sh_mask;
    logic [4:0]  sh_ftype [FDEPTH];
    logic [31:0] sh_farg  [FDEPTH];
    logic [4:0]  sh_ntype [NDEPTH];
    logic [31:0] sh_narg  [NDEPTH];
    int          sh_fhead, sh_ftail, sh_nhead, sh_ntail;
    logic [31:0] sh_fcnt [5];
    logic [31:0] sh_ncnt [5];

    command_t pending_cmds[$];
    outcome_t expected_outcomes[$];

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_send;
    bit  failed;

    function automatic bit type_queued(bit fault, logic [4:0] t);
        int i;
        i = fault ? sh_ftail : sh_ntail;
        while (i != (fault ? sh_fhead : sh_nhead))
        begin
            if ((fault ? sh_ftype[i] : sh_ntype[i]) == t)
                return 1'b1;
            i = (i + 1) % (fault ? FDEPTH : NDEPTH);
        end
        return 1'b0;
    endfunction

    // Advances the shadow queues by one command and returns its result.
    function automatic outcome_t queue_outcome(command_t c);
        outcome_t r;
        int nxt;
        r = '0;
        case (c.mode)
            MODE_PUSH:
            begin
                if (c.etype != 0 && c.etype < NTYPES)
                begin
                    if (sh_mask[c.etype] && type_queued(c.sel, c.etype))
                    begin
                        if (c.sel) sh_fcnt[C_COAL]++;
                        else       sh_ncnt[C_COAL]++;
                        r.ok = 1'b1;
                    end
                    else if (c.sel)
                    begin
                        // full fault queue overwrites its oldest entry
                        nxt = (sh_fhead + 1) % FDEPTH;
                        if (nxt == sh_ftail)
                        begin
                            sh_ftail = (sh_ftail + 1) % FDEPTH;
                            sh_fcnt[C_DROP]++;
                        end
                        sh_ftype[sh_fhead] = c.etype;
                        sh_farg[sh_fhead]  = c.arg;
                        sh_fhead = nxt;
                        sh_fcnt[C_PUSH]++;
                        r.ok = 1'b1;
                    end
                    else
                    begin
                        nxt = (sh_nhead + 1) % NDEPTH;
                        if (nxt == sh_ntail)
                            sh_ncnt[C_DROP]++;
                        else
                        begin
                            sh_ntype[sh_nhead] = c.etype;
                            sh_narg[sh_nhead]  = c.arg;
                            sh_nhead = nxt;
                            sh_ncnt[C_PUSH]++;
                            r.ok = 1'b1;
                        end
                    end
                end
            end
            MODE_POP:
            begin
                if (sh_fhead != sh_ftail)
                begin
                    r.ok = 1'b1;
                    r.etype = sh_ftype[sh_ftail];
                    r.arg = sh_farg[sh_ftail];
                    sh_ftail = (sh_ftail + 1) % FDEPTH;
                    sh_fcnt[C_POP]++;
                end
                else if (sh_nhead != sh_ntail)
                begin
                    r.ok = 1'b1;
                    r.etype = sh_ntype[sh_ntail];
                    r.arg = sh_narg[sh_ntail];
                    sh_ntail = (sh_ntail + 1) % NDEPTH;
                    sh_ncnt[C_POP]++;
                end
            end
            MODE_IGNORE:
            begin
                sh_ncnt[C_IGN]++;
                r.ok = 1'b1;
            end
            default:
            begin
                r.ok = 1'b1;
                r.c_push = c.sel ? sh_fcnt[C_PUSH] : sh_ncnt[C_PUSH];
                r.c_pop  = c.sel ? sh_fcnt[C_POP]  : sh_ncnt[C_POP];
                r.c_drop = c.sel ? sh_fcnt[C_DROP] : sh_ncnt[C_DROP];
                r.c_coal = c.sel ? sh_fcnt[C_COAL] : sh_ncnt[C_COAL];
                r.c_ign  = c.sel ? sh_fcnt[C_IGN]  : sh_ncnt[C_IGN];
            end
        endcase
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Driver: pops pending commands and presents them until transferred
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            mode       <= '0;
            queue_sel  <= 1'b0;
            event_type <= '0;
            event_arg  <= '0;
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
            if (!in_valid || in_ready)
            begin
                if (!hold_send && pending_cmds.size() > 0
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    command_t c;
                    c = pending_cmds.pop_front();
                    // prediction happens when the command is taken for driving;
                    // transfers are in order so this matches block order
                    expected_outcomes.push_back(queue_outcome(c));
                    in_valid   <= 1'b1;
                    mode       <= c.mode;
                    queue_sel  <= c.sel;
                    event_type <= c.etype;
                    event_arg  <= c.arg;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compares each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_outcomes.size() == 0)
            begin
                $display("%0t: result with none expected: ok=%0b type=%0d arg=%h",
                         $realtime, ok, out_type, out_arg);
                failed = 1'b1;
            end
            else
            begin
                outcome_t e;
                outcome_t a;
                e = expected_outcomes.pop_front();
                a = {ok, out_type, out_arg, pushed_count, popped_count,
                     dropped_count, coalesced_count, ignored_count};
                if (e.ok !== a.ok)
                begin
                    $display("%0t: ok exp %0b got %0b", $realtime, e.ok, a.ok);
                    failed = 1'b1;
                end
                if (e.etype !== a.etype)
                begin
                    $display("%0t: out_type exp %0d got %0d", $realtime, e.etype, a.etype);
                    failed = 1'b1;
                end
                if (e.arg !== a.arg)
                begin
                    $display("%0t: out_arg exp %h got %h", $realtime, e.arg, a.arg);
                    failed = 1'b1;
                end
                if (e.c_push !== a.c_push)
                begin
                    $display("%0t: pushed exp %0d got %0d", $realtime, e.c_push, a.c_push);
                    failed = 1'b1;
                end
                if (e.c_pop !== a.c_pop)
                begin
                    $display("%0t: popped exp %0d got %0d", $realtime, e.c_pop, a.c_pop);
                    failed = 1'b1;
                end
                if (e.c_drop !== a.c_drop)
                begin
                    $display("%0t: dropped exp %0d got %0d", $realtime, e.c_drop, a.c_drop);
                    failed = 1'b1;
                end
                if (e.c_coal !== a.c_coal)
                begin
                    $display("%0t: coalesced exp %0d got %0d", $realtime, e.c_coal, a.c_coal);
                    failed = 1'b1;
                end
                if (e.c_ign !== a.c_ign)
                begin
                    $display("%0t: ignored exp %0d got %0d", $realtime, e.c_ign, a.c_ign);
                    failed = 1'b1;
                end
            end
        end
    end

    function automatic command_t make_cmd(mode_t m, logic s, logic [4:0] t, logic [31:0] a);
        command_t c;
        c.mode = m;
        c.sel = s;
        c.etype = t;
        c.arg = a;
        return c;
    endfunction

    // Random command mix: mostly pushes of few types so coalescing and
    // both full-queue cases are hit, with pops to drain.
    function automatic command_t random_cmd();
        int r;
        logic [4:0] t;
        r = $urandom_range(99);
        t = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(4, 1));
        if (r < 50)
            return make_cmd(MODE_PUSH, 1'($urandom), t, $urandom);
        else if (r < 82)
            return make_cmd(MODE_POP, 1'($urandom), 5'($urandom), $urandom);
        else if (r < 90)
            return make_cmd(MODE_IGNORE, 1'($urandom), 5'($urandom), $urandom);
        else
            return make_cmd(MODE_STATS, 1'($urandom), 5'($urandom), $urandom);
    endfunction

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || expected_outcomes.size() > 0 || in_valid)
            @(posedge clk);
        // every result has arrived here; add an idle tail before the next phase
        repeat (40) @(posedge clk);
    endtask

    task automatic write_mask(logic [31:0] v);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        sh_mask = v;
    endtask

    task automatic run_phase(int n, int s_pct, int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < n; i++)
            pending_cmds.push_back(random_cmd());
        wait_drained();
    endtask

    initial
    begin
        failed = 1'b0;
        hold_send = 1'b0;
        send_idle_pct = 31;
        recv_idle_pct = 49;
        sh_mask = '0;
        sh_fhead = 0; sh_ftail = 0; sh_nhead = 0; sh_ntail = 0;
        for (int i = 0; i < 5; i++)
        begin
            sh_fcnt[i] = '0;
            sh_ncnt[i] = '0;
        end
        cfg_we = 1'b0;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty pop, invalid type, extremes, overflow of the fault queue
        pending_cmds.push_back(make_cmd(MODE_POP, 1'b0, 5'd0, 32'h0));
        pending_cmds.push_back(make_cmd(MODE_PUSH, 1'b0, 5'd0, 32'hFFFFFFFF));
        pending_cmds.push_back(make_cmd(MODE_PUSH, 1'b1, 5'd31, 32'hFFFFFFFF));
        pending_cmds.push_back(make_cmd(MODE_PUSH, 1'b0, 5'd1, 32'h0));
        for (int i = 0; i < 9; i++)
            pending_cmds.push_back(make_cmd(MODE_PUSH, 1'b1, 5'(i + 2), $urandom));
        pending_cmds.push_back(make_cmd(MODE_STATS, 1'b1, 5'd0, 32'h0));
        pending_cmds.push_back(make_cmd(MODE_IGNORE, 1'b1, 5'd31, 32'hFFFFFFFF));
        pending_cmds.push_back(make_cmd(MODE_STATS, 1'b0, 5'd31, 32'hFFFFFFFF));
        for (int i = 0; i < 9; i++)
            pending_cmds.push_back(make_cmd(MODE_POP, 1'b1, 5'd31, 32'h0));
        wait_drained();

        write_mask(32'hFFFFFFFF);
        pending_cmds.push_back(make_cmd(MODE_PUSH, 1'b0, 5'd31, 32'h12345678));
        pending_cmds.push_back(make_cmd(MODE_PUSH, 1'b0, 5'd31, 32'h87654321));
        pending_cmds.push_back(make_cmd(MODE_PUSH, 1'b1, 5'd1, 32'hA5A5A5A5));
        pending_cmds.push_back(make_cmd(MODE_PUSH, 1'b1, 5'd1, 32'h5A5A5A5A));
        pending_cmds.push_back(make_cmd(MODE_STATS, 1'b1, 5'd0, 32'h0));
        wait_drained();

        // Hold the sender until every result has arrived
        hold_send = 1'b1;
        for (int i = 0; i < 6; i++)
            pending_cmds.push_back(random_cmd());
        while (expected_outcomes.size() > 0)
            @(posedge clk);
        hold_send = 1'b0;
        wait_drained();

        run_phase(250, 31, 49);
        write_mask($urandom);
        run_phase(250, 49, 31);
        write_mask(32'h0000001E);
        run_phase(250, 0, 0);
        write_mask(32'h0);
        run_phase(200, 31, 49);
        write_mask(32'hFFFFFFFF);
        run_phase(200, 0, 0);

        if (!failed)
            $display("two_priority_event_queue: match");
        else
            $display("two_priority_event_queue: mismatch");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("two_priority_event_queue: mismatch");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/tpeq_pkg.sv
rtl/tpeq_front.sv
rtl/tpeq_back.sv
rtl/two_priority_event_queue.sv
sim/two_priority_event_queue_test.sv
